FILE: rtl/core/orol_pkg.sv
package orol_pkg;

    localparam int SLOTS       = 16;
    localparam int LENGTH_BITS = 24;

    localparam int ADDR_W = 48;
    localparam int LEN_W  = 24;
    localparam int OFFS_W = 28;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);
    // Wide enough for the total length of a full ring.
    localparam int SUM_W = LENGTH_BITS + CNT_W;
    localparam int CMP_W = ((SUM_W > OFFS_W) ? SUM_W : OFFS_W) + 1;

    typedef logic [ADDR_W-1:0]      t_addr;
    typedef logic [LENGTH_BITS-1:0] t_slot_len;

    typedef enum logic {
        OP_ADD  = 1'b0,
        OP_FIND = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic             shift;
        logic             tail_new;
        logic [SLOTS-1:0] load_sel;
    } t_ring_ctl;

    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctl;

endpackage

FILE: rtl/core/orol_cell.sv
module orol_cell
    import orol_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  t_addr     i_next_addr,
    input  t_slot_len i_next_len,
    input  t_addr     i_new_addr,
    input  t_slot_len i_new_len,
    output t_addr     o_addr,
    output t_slot_len o_len
);

    t_addr     r_addr;
    t_slot_len r_len;

    // A shift takes the neighbor's entry; a load takes the incoming word.
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_addr <= i_next_addr;
            r_len  <= i_next_len;
        end else if (i_ctl.load) begin
            r_addr <= i_new_addr;
            r_len  <= i_new_len;
        end
    end

    assign o_addr = r_addr;
    assign o_len  = r_len;

endmodule

FILE: rtl/core/orol_ctrl.sv
module orol_ctrl
    import orol_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_opcode,
    input  logic [OFFS_W-1:0] i_char_offset,
    input  t_addr             i_head_addr,
    input  t_slot_len         i_head_len,
    output t_ring_ctl         o_ring,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_hit,
    output t_addr             o_result_address,
    output logic [LEN_W-1:0]  o_result_length,
    output logic [LEN_W-1:0]  o_byte_in_entry
);

    t_state             r_state;
    t_state             n_state;
    logic [CNT_W-1:0]   r_count;
    logic [IDX_W-1:0]   r_step;
    logic [SUM_W-1:0]   r_sum;
    logic [OFFS_W-1:0]  r_target;
    logic               r_res_hit;
    t_addr              r_res_addr;
    logic [LEN_W-1:0]   r_res_len;
    logic [LEN_W-1:0]   r_res_within;
    logic               r_out_valid;
    logic               n_out_valid;
    logic               r_out_hit;
    t_addr              r_out_addr;
    logic [LEN_W-1:0]   r_out_len;
    logic [LEN_W-1:0]   r_out_within;

    logic               accept;
    logic               is_find;
    logic               full;
    logic               last_step;
    logic               out_free;
    logic               out_load;
    logic               head_valid;
    logic               in_range;
    logic [CMP_W-1:0]   sum_ext;
    logic [CMP_W-1:0]   tgt_ext;
    logic [CMP_W-1:0]   end_ext;
    logic [CMP_W-1:0]   diff_ext;

    assign is_find   = (t_op'(i_opcode) == OP_FIND);
    assign full      = (r_count == CNT_W'(SLOTS));
    assign last_step = (r_step == IDX_W'(SLOTS - 1));
    assign out_free  = !r_out_valid || !i_out_stall;
    assign accept    = i_in_valid && !o_in_stall;

    // The head cell holds the entry at position r_step in age order.
    assign head_valid = (CNT_W'(r_step) < r_count);
    assign sum_ext    = CMP_W'(r_sum);
    assign tgt_ext    = CMP_W'(r_target);
    assign end_ext    = sum_ext + CMP_W'(i_head_len);
    assign diff_ext   = tgt_ext - sum_ext;
    assign in_range   = (sum_ext <= tgt_ext) && (tgt_ext < end_ext);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = is_find ? ST_WALK : ST_FIN;
                end
            end
            ST_WALK: begin
                if (last_step) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = 1'b1;
        out_load   = 1'b0;
        o_ring     = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid && !is_find) begin
                    if (full) begin
                        // The oldest entry drops out of the head cell.
                        o_ring.shift    = 1'b1;
                        o_ring.tail_new = 1'b1;
                    end else begin
                        o_ring.load_sel[r_count[IDX_W-1:0]] = 1'b1;
                    end
                end
            end
            ST_WALK: begin
                o_ring.shift = 1'b1;
            end
            ST_FIN: begin
                out_load = out_free;
            end
            default: o_in_stall = 1'b1;
        endcase
    end

    assign n_out_valid = out_load || (r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (accept && !is_find && !full) begin
                r_count <= r_count + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (is_find) begin
                r_target     <= i_char_offset;
                r_sum        <= '0;
                r_step       <= '0;
                r_res_hit    <= 1'b0;
                r_res_addr   <= '0;
                r_res_len    <= '0;
                r_res_within <= '0;
            end else begin
                r_res_hit    <= full;
                r_res_addr   <= full ? i_head_addr : '0;
                r_res_len    <= '0;
                r_res_within <= '0;
            end
        end else if (r_state == ST_WALK) begin
            r_step <= r_step + IDX_W'(1);
            if (head_valid) begin
                r_sum <= r_sum + SUM_W'(i_head_len);
                // Only the first entry that covers the offset counts.
                if (!r_res_hit && in_range) begin
                    r_res_hit    <= 1'b1;
                    r_res_addr   <= i_head_addr;
                    r_res_len    <= LEN_W'(i_head_len);
                    r_res_within <= diff_ext[LEN_W-1:0];
                end
            end
        end
        if (out_load) begin
            r_out_hit    <= r_res_hit;
            r_out_addr   <= r_res_addr;
            r_out_len    <= r_res_len;
            r_out_within <= r_res_within;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_hit            = r_out_hit;
    assign o_result_address = r_out_addr;
    assign o_result_length  = r_out_len;
    assign o_byte_in_entry  = r_out_within;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(SLOTS))
        else $error("entry count exceeds ring size");

    a_load_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(o_ring.load_sel) && (!o_ring.shift || o_ring.load_sel == '0))
        else $error("cell load select not one-hot or mixed with shift");

    a_walk_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK && last_step) |=> (r_state == ST_FIN))
        else $error("walk did not finish after a full rotation");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid ##1 r_out_valid) |-> ($past(r_state) == ST_FIN))
        else $error("result word appeared without a finished item");

    a_count_stable_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) |=> $stable(r_count))
        else $error("entry count changed during a lookup");

endmodule

FILE: rtl/core/overwriting_ring_offset_lookup.sv
// Overwriting ring of handle/length entries with byte-offset lookup.
//
// Input channel (i_in_valid / o_in_stall) takes one word per item: an add
// (i_opcode 0) stores i_entry_address and i_entry_length as the newest entry,
// a find (i_opcode 1) locates the entry holding byte i_char_offset.
// Output channel (o_out_valid / i_out_stall) returns one result word per item.
//
// Entries sit in a chain of SLOTS cells, oldest in the head cell. An add into
// a full ring shifts the chain by one and returns the handle that falls out.
// A find rotates the whole chain once, one cell per cycle, summing lengths at
// the head, so the chain is back in order when the walk ends.
// An add goes from acceptance through the finish state to the output register;
// a find walks the chain first. No new item is accepted until the current one
// is finished, so the rotation of the cell chain holds off the next item.
// A finished result waits in a holding register while the output word is
// stalled, and the next item is accepted once that register has moved on.
// Reset empties the ring and drops any pending result.
module overwriting_ring_offset_lookup
    import orol_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_opcode,
    input  logic [ADDR_W-1:0] i_entry_address,
    input  logic [LEN_W-1:0]  i_entry_length,
    input  logic [OFFS_W-1:0] i_char_offset,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_hit,
    output logic [ADDR_W-1:0] o_result_address,
    output logic [LEN_W-1:0]  o_result_length,
    output logic [LEN_W-1:0]  o_byte_in_entry
);

    t_ring_ctl ring;
    t_addr     cell_addr [SLOTS];
    t_slot_len cell_len  [SLOTS];
    t_slot_len new_len;
    t_addr     tail_addr;
    t_slot_len tail_len;

    assign new_len = LENGTH_BITS'(i_entry_length);

    // The last cell refills from the head during a lookup, or takes the new
    // entry when a full ring is overwritten.
    assign tail_addr = ring.tail_new ? i_entry_address : cell_addr[0];
    assign tail_len  = ring.tail_new ? new_len : cell_len[0];

    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        t_cell_ctl ctl;
        t_addr     next_addr;
        t_slot_len next_len;

        assign ctl.shift = ring.shift;
        assign ctl.load  = ring.load_sel[g];

        if (g == SLOTS - 1) begin : g_tail
            assign next_addr = tail_addr;
            assign next_len  = tail_len;
        end else begin : g_mid
            assign next_addr = cell_addr[g+1];
            assign next_len  = cell_len[g+1];
        end

        orol_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (ctl),
            .i_next_addr (next_addr),
            .i_next_len  (next_len),
            .i_new_addr  (i_entry_address),
            .i_new_len   (new_len),
            .o_addr      (cell_addr[g]),
            .o_len       (cell_len[g])
        );
    end

    orol_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_opcode         (i_opcode),
        .i_char_offset    (i_char_offset),
        .i_head_addr      (cell_addr[0]),
        .i_head_len       (cell_len[0]),
        .o_ring           (ring),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_hit            (o_hit),
        .o_result_address (o_result_address),
        .o_result_length  (o_result_length),
        .o_byte_in_entry  (o_byte_in_entry)
    );

endmodule
